// ===== hdl/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants, types and hash helpers for the minimizer seed extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

  // Sizing
  localparam int KMER_LEN   = 15;
  localparam int WINDOW_LEN = 10;
  localparam int SPAN       = KMER_LEN + WINDOW_LEN - 1;
  localparam int WIN_W      = 2 * SPAN;
  localparam int KM_W       = 2 * KMER_LEN;
  localparam int IDX_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int HASH_W     = 30;
  localparam int POS_W      = 32;
  localparam int RUN_W      = 16;

  localparam logic [RUN_W-1:0] RUN_THR  = RUN_W'(KMER_LEN + WINDOW_LEN - 2);
  localparam logic [RUN_W-1:0] RUN_MAX  = '1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);
  localparam logic [POS_W-1:0] WIN_LEN_POS = POS_W'(WINDOW_LEN);

  // Input byte codes
  localparam logic [7:0] CH_END    = 8'h45;  // 'E'
  localparam logic [7:0] CH_BREAK  = 8'h4E;  // 'N'
  localparam logic [7:0] COMP_FLIP = 8'h04;

  // Mix shift amounts
  localparam int SH_A = 21;
  localparam int SH_B = 24;
  localparam int SH_C = 14;
  localparam int SH_D = 28;
  localparam int SH_E = 31;

  typedef logic [KM_W-1:0] kmer_t;

  // Controller -> datapath
  typedef struct packed {
    logic             take;
    logic             issue;
    logic [IDX_W-1:0] issue_idx;
    logic             load_flags;
    logic             emit_seed;
    logic [IDX_W-1:0] emit_idx;
    logic             emit_marker;
    logic             emit_term;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic acc_end;
    logic acc_go;
    logic acc_fin;
    logic fin_q;
    logic pipe_busy;
    logic cur_flag;
    logic out_ready;
  } sts_t;

  // Invertible mix, split into four register-bounded steps
  function automatic kmer_t mix_s1(input kmer_t k);
    kmer_t t;
    t = ~k + (k << SH_A);
    return t ^ (t >> SH_B);
  endfunction

  function automatic kmer_t mix_s2(input kmer_t k);
    kmer_t t;
    t = k + (k << 3) + (k << 8);
    return t ^ (t >> SH_C);
  endfunction

  function automatic kmer_t mix_s3(input kmer_t k);
    kmer_t t;
    t = k + (k << 2) + (k << 4);
    return t ^ (t >> SH_D);
  endfunction

  function automatic kmer_t mix_s4(input kmer_t k);
    return k + (k << SH_E);
  endfunction

  // Reverse the order of the 2-bit base codes
  function automatic kmer_t rev_bases(input kmer_t s);
    kmer_t r;
    for (int j = 0; j < KMER_LEN; j++) begin
      r[2*(KMER_LEN-1-j) +: 2] = s[2*j +: 2];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/minimizer_seed_extractor_core.sv =====
// ----------------------------------------------------------------------------
// minimizer_seed_extractor_core
// Canonical k-mer minimizer seed extractor, one ASCII base per input beat.
// ----------------------------------------------------------------------------
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// input    | in_valid / in_stall  | base_char, stream_end
// output   | out_valid / out_stall| seed_hash, seed_pos, strand, end_of_read,
//          |                      | last
//
// A base that does not complete a window is simply taken; an end-of-read base
// also emits a read-end marker. A base that completes a window issues every
// window slot into the five-stage select/hash pipeline, waits for it to drain,
// then walks the seed table one window slot per cycle while the output is
// not stalled. A stream end adds a terminator beat. Output stalls hold the
// seed walk and markers. Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module minimizer_seed_extractor_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 base_char,
  input  wire logic                       stream_end,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [mse_pkg::HASH_W-1:0]      seed_hash,
  output logic [mse_pkg::POS_W-1:0]       seed_pos,
  output logic                            strand,
  output logic                            end_of_read,
  output logic                            last
);
  import mse_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mse_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .base_char   (base_char),
    .stream_end  (stream_end),
    .cmd         (cmd),
    .sts         (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .seed_hash   (seed_hash),
    .seed_pos    (seed_pos),
    .strand      (strand),
    .end_of_read (end_of_read),
    .last        (last)
  );

endmodule

`default_nettype wire

// ===== hdl/mse_dp.sv =====
// ----------------------------------------------------------------------------
// mse_dp
// Datapath: base windows, k-mer select, pipelined hash, minimum tracking,
// per-window seed table and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_dp (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [7:0]                base_char,
  input  wire logic                      stream_end,
  input  wire mse_pkg::cmd_t             cmd,
  output mse_pkg::sts_t                  sts,
  input  wire logic                      out_stall,
  output logic                           out_valid,
  output logic [mse_pkg::HASH_W-1:0]     seed_hash,
  output logic [mse_pkg::POS_W-1:0]      seed_pos,
  output logic                           strand,
  output logic                           end_of_read,
  output logic                           last
);
  import mse_pkg::*;

  typedef struct packed {
    kmer_t            key;
    logic             ok;
    logic             st;
    logic             gt;
    logic [IDX_W-1:0] idx;
  } pipe_t;

  localparam logic [WINDOW_LEN-1:0] IDX_ONE = WINDOW_LEN'(1);

  // Stream state
  logic [WIN_W-1:0] fwd_win;
  logic [WIN_W-1:0] rc_win;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] pos_base;
  logic [RUN_W-1:0] run_len;
  logic [POS_W-1:0] prev_pos;
  logic             fin_q;

  // Hash pipeline
  pipe_t      pa;
  logic       pa_v;
  pipe_t      hs [4];
  pipe_t      hs_d [4];
  logic [3:0] hs_v;

  // Minimum and seed table
  kmer_t                 best;
  logic                  best_any;
  kmer_t                 e_hash [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] e_ok;
  logic [WINDOW_LEN-1:0] e_st;
  logic [WINDOW_LEN-1:0] e_gt;
  logic [WINDOW_LEN-1:0] flags;

  // Input decode
  logic             is_end;
  logic             is_brk;
  logic [1:0]       fcode;
  logic [1:0]       rcode;
  logic [7:0]       comp_char;
  logic [RUN_W-1:0] run_next;
  logic [POS_W-1:0] pos_next;

  // K-mer select
  logic [IDX_W-1:0] age;
  kmer_t            f_km;
  kmer_t            r_km;
  logic [POS_W-1:0] issue_loc;

  // Emit helpers
  logic                  out_ready;
  logic [WINDOW_LEN-1:0] flags_rest;

  always_comb begin
    is_end    = (base_char == CH_END);
    is_brk    = (base_char == CH_BREAK);
    comp_char = base_char ^ COMP_FLIP;
    fcode     = base_char[2:1];
    rcode     = comp_char[2:1];
    pos_next  = position + POS_W'(1);
    if (is_brk) begin
      run_next = '0;
    end else if (run_len == RUN_MAX) begin
      run_next = run_len;
    end else begin
      run_next = run_len + RUN_W'(1);
    end
  end

  // Pick k-mer at the issue index (oldest first) from both windows
  always_comb begin
    age       = LAST_IDX - cmd.issue_idx;
    f_km      = KM_W'(fwd_win >> {age, 1'b0});
    r_km      = rev_bases(KM_W'(rc_win >> {age, 1'b0}));
    issue_loc = pos_base + POS_W'(cmd.issue_idx);
  end

  assign out_ready  = !out_valid || !out_stall;
  assign flags_rest = flags & ~(IDX_ONE << cmd.emit_idx);

  always_comb begin
    sts.acc_end   = is_end;
    sts.acc_go    = !is_end && (run_next > RUN_THR);
    sts.acc_fin   = stream_end;
    sts.fin_q     = fin_q;
    sts.pipe_busy = pa_v || (|hs_v);
    sts.cur_flag  = flags[cmd.emit_idx];
    sts.out_ready = out_ready;
  end

  // Stream state: windows, position, run length, last emitted position
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_win  <= '0;
      rc_win   <= '0;
      position <= '0;
      pos_base <= '0;
      run_len  <= '0;
      prev_pos <= '0;
      fin_q    <= 1'b0;
    end else if (cmd.take) begin
      fin_q <= stream_end;
      if (is_end) begin
        position <= '0;
        run_len  <= '0;
        prev_pos <= '0;
      end else begin
        position <= pos_next;
        pos_base <= pos_next - WIN_LEN_POS;
        run_len  <= run_next;
        if (!is_brk) begin
          fwd_win <= WIN_W'(fwd_win << 2) | WIN_W'(fcode);
          rc_win  <= WIN_W'(rc_win << 2) | WIN_W'(rcode);
        end
      end
    end else if (cmd.emit_term) begin
      fwd_win  <= '0;
      rc_win   <= '0;
      position <= '0;
      run_len  <= '0;
      prev_pos <= '0;
      fin_q    <= 1'b0;
    end else if (cmd.emit_seed) begin
      prev_pos <= pos_base + POS_W'(cmd.emit_idx);
    end
  end

  // Select stage, then four mix stages
  always_ff @(posedge clk) begin
    if (rst) begin
      pa_v <= 1'b0;
      hs_v <= '0;
    end else begin
      pa_v <= cmd.issue;
      hs_v <= {hs_v[2:0], pa_v};
    end
  end

  // Next contents of the mix stages
  always_comb begin
    hs_d[0]     = pa;
    hs_d[0].key = mix_s1(pa.key);
    hs_d[1]     = hs[0];
    hs_d[1].key = mix_s2(hs[0].key);
    hs_d[2]     = hs[1];
    hs_d[2].key = mix_s3(hs[1].key);
    hs_d[3]     = hs[2];
    hs_d[3].key = mix_s4(hs[2].key);
  end

  always_ff @(posedge clk) begin
    pa.ok  <= (f_km != r_km);
    pa.st  <= (f_km > r_km);
    pa.key <= (f_km > r_km) ? r_km : f_km;
    pa.gt  <= (issue_loc > prev_pos);
    pa.idx <= cmd.issue_idx;
    hs[0]  <= hs_d[0];
    hs[1]  <= hs_d[1];
    hs[2]  <= hs_d[2];
    hs[3]  <= hs_d[3];
  end

  // Seed table write and running minimum
  always_ff @(posedge clk) begin
    if (hs_v[3]) begin
      e_hash[hs[3].idx] <= hs[3].key;
      e_ok[hs[3].idx]   <= hs[3].ok;
      e_st[hs[3].idx]   <= hs[3].st;
      e_gt[hs[3].idx]   <= hs[3].gt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_any <= 1'b0;
    end else if (cmd.take) begin
      best_any <= 1'b0;
    end else if (hs_v[3] && hs[3].ok && (!best_any || hs[3].key < best)) begin
      best     <= hs[3].key;
      best_any <= 1'b1;
    end
  end

  // Emit flags: candidate, holds the minimum, beyond the last seed
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (cmd.load_flags) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        flags[i] <= e_ok[i] && e_gt[i] && (e_hash[i] == best);
      end
    end else if (cmd.emit_seed) begin
      flags <= flags_rest;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_seed || cmd.emit_marker || cmd.emit_term) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_seed) begin
      seed_hash   <= HASH_W'(e_hash[cmd.emit_idx]);
      seed_pos    <= pos_base + POS_W'(cmd.emit_idx);
      strand      <= e_st[cmd.emit_idx];
      end_of_read <= 1'b0;
      last        <= (flags_rest == '0) && !fin_q;
    end else if (cmd.emit_marker) begin
      seed_hash   <= '1;
      seed_pos    <= '0;
      strand      <= 1'b0;
      end_of_read <= 1'b1;
      last        <= !fin_q;
    end else if (cmd.emit_term) begin
      seed_hash   <= '1;
      seed_pos    <= '0;
      strand      <= 1'b1;
      end_of_read <= 1'b1;
      last        <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mse_ctrl.sv =====
// ----------------------------------------------------------------------------
// mse_ctrl
// Controller: sequences accept, hash issue, drain, seed walk and markers.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire mse_pkg::sts_t sts,
  output mse_pkg::cmd_t      cmd
);
  import mse_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_HASH  = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_EMIT  = 6'b001000,
    ST_MARK  = 6'b010000,
    ST_TERM  = 6'b100000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] issue_idx;
  logic [IDX_W-1:0] issue_idx_next;
  logic [IDX_W-1:0] emit_idx;
  logic [IDX_W-1:0] emit_idx_next;
  state_t           after_item;

  assign in_stall   = (state != ST_IDLE);
  assign after_item = sts.fin_q ? ST_TERM : ST_IDLE;

  // Next state and commands
  always_comb begin
    state_next     = state;
    issue_idx_next = issue_idx;
    emit_idx_next  = emit_idx;
    cmd            = '0;
    cmd.issue_idx  = issue_idx;
    cmd.emit_idx   = emit_idx;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.acc_end) begin
            state_next = ST_MARK;
          end else if (sts.acc_go) begin
            state_next = ST_HASH;
          end else if (sts.acc_fin) begin
            state_next = ST_TERM;
          end
        end
      end
      ST_HASH: begin
        cmd.issue = 1'b1;
        if (issue_idx == LAST_IDX) begin
          issue_idx_next = '0;
          state_next     = ST_DRAIN;
        end else begin
          issue_idx_next = issue_idx + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          cmd.load_flags = 1'b1;
          emit_idx_next  = '0;
          state_next     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit_seed = sts.cur_flag && sts.out_ready;
        if (!sts.cur_flag || sts.out_ready) begin
          if (emit_idx == LAST_IDX) begin
            emit_idx_next = '0;
            state_next    = after_item;
          end else begin
            emit_idx_next = emit_idx + IDX_W'(1);
          end
        end
      end
      ST_MARK: begin
        if (sts.out_ready) begin
          cmd.emit_marker = 1'b1;
          state_next      = after_item;
        end
      end
      ST_TERM: begin
        if (sts.out_ready) begin
          cmd.emit_term = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_idx <= '0;
      emit_idx  <= '0;
    end else begin
      state     <= state_next;
      issue_idx <= issue_idx_next;
      emit_idx  <= emit_idx_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mse_checker.sv =====
// ----------------------------------------------------------------------------
// mse_checker
// Port-level checks for the minimizer seed extractor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic [7:0]                 base_char,
  input wire logic                       stream_end,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [mse_pkg::HASH_W-1:0] seed_hash,
  input wire logic [mse_pkg::POS_W-1:0]  seed_pos,
  input wire logic                       strand,
  input wire logic                       end_of_read,
  input wire logic                       last
);

  // No output beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // Markers carry all-ones hash and zero position
  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_read |-> (seed_hash == '1) && (seed_pos == '0))
    else $error("marker payload malformed");

  // Real seeds always lie beyond position zero
  a_seed_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !end_of_read |-> (seed_pos != '0))
    else $error("seed at position zero");

  // Terminator is always the final beat of its item
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_read && strand |-> last)
    else $error("terminator without last");

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && out_stall && !rst) |->
      out_valid && $stable(seed_hash) && $stable(seed_pos) && $stable(last))
    else $error("stalled output beat changed");

endmodule

bind minimizer_seed_extractor_core mse_checker u_mse_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_minimizer_seed_extractor_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_minimizer_seed_extractor_core
// Self-checking bench for the minimizer seed extractor. A short table of
// directed bases is followed by random reads: mostly clean nucleotide runs
// long enough to fill the window, some low-complexity repeats, short reads,
// run breaks and raw byte noise, with read ends and stream ends mixed in.
// A local model of the extractor predicts every seed and marker, and each
// output beat is checked field by field against the oldest prediction.
// Both channels idle and stall at random throughout.
// ----------------------------------------------------------------------------

module tb_minimizer_seed_extractor_core;
  import mse_pkg::*;

  localparam int TOTAL_ITEMS = 370;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int DIR_ROWS    = 24;

  // How a directed row is checked
  typedef enum logic [2:0] {
    CHK_PREDICT,
    CHK_NONE,
    CHK_MARK,
    CHK_TERM,
    CHK_MARK_TERM
  } check_e;

  typedef struct {
    logic [7:0] b;
    logic       fin;
    check_e     chk;
  } dir_row_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [POS_W-1:0]  pos;
    logic              rc;
    logic              eor;
    logic              last_flag;
  } seed_rec_t;

  localparam logic [7:0] NUC_TBL [0:7] = '{8'h41, 8'h43, 8'h47, 8'h54,
                                           8'h61, 8'h63, 8'h67, 8'h74};

  // Directed bases
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{8'h41,    1'b0, CHK_NONE},       // first base after reset
    '{8'h00,    1'b0, CHK_NONE},
    '{8'hFF,    1'b0, CHK_NONE},
    '{CH_BREAK, 1'b0, CHK_NONE},
    '{CH_END,   1'b0, CHK_MARK},       // end of read
    '{CH_END,   1'b1, CHK_MARK_TERM},  // end of read on the last beat
    '{CH_BREAK, 1'b1, CHK_TERM},
    '{8'h80,    1'b1, CHK_TERM},
    '{8'h61,    1'b0, CHK_PREDICT},
    '{8'h63,    1'b0, CHK_PREDICT},
    '{8'h67,    1'b0, CHK_PREDICT},
    '{8'h74,    1'b0, CHK_PREDICT},
    '{8'h43,    1'b0, CHK_PREDICT},
    '{8'h47,    1'b0, CHK_PREDICT},
    '{8'h54,    1'b0, CHK_PREDICT},
    '{8'h7F,    1'b0, CHK_PREDICT},
    '{8'h01,    1'b0, CHK_PREDICT},
    '{8'hFE,    1'b0, CHK_PREDICT},
    '{CH_BREAK, 1'b0, CHK_PREDICT},
    '{8'h67,    1'b0, CHK_PREDICT},
    '{CH_END,   1'b0, CHK_PREDICT},
    '{8'h41,    1'b0, CHK_PREDICT},
    '{8'h55,    1'b0, CHK_PREDICT},
    '{8'hAA,    1'b1, CHK_PREDICT}
  };

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [7:0]        base_char  = 8'h00;
  logic              stream_end = 1'b0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [HASH_W-1:0] seed_hash;
  logic [POS_W-1:0]  seed_pos;
  logic              strand;
  logic              end_of_read;
  logic              last;

  // Model state
  logic [WIN_W-1:0] fwd_bases = '0;
  logic [WIN_W-1:0] rc_bases  = '0;
  logic [POS_W-1:0] read_pos  = '0;
  logic [RUN_W-1:0] clean_run = '0;
  logic [POS_W-1:0] seed_floor = '0;

  seed_rec_t step_seeds [$];
  seed_rec_t pending_seeds [$];

  int fails       = 0;
  int items_sent  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int seeds_seen  = 0;
  int marks_seen  = 0;
  int terms_seen  = 0;
  int stall_mode  = 0;
  int stall_left  = 0;

  always #6 clk = ~clk;

  minimizer_seed_extractor_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .base_char   (base_char),
    .stream_end  (stream_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .seed_hash   (seed_hash),
    .seed_pos    (seed_pos),
    .strand      (strand),
    .end_of_read (end_of_read),
    .last        (last)
  );

  // Invertible 64-bit mix, folded to 2*KMER_LEN bits
  function automatic logic [HASH_W-1:0] scramble30(input logic [KM_W-1:0] key);
    logic [63:0] k;
    logic [63:0] m;
    m = (64'd1 << KM_W) - 64'd1;
    k = {{(64-KM_W){1'b0}}, key};
    k = (~k + (k << SH_A)) & m;
    k = k ^ (k >> SH_B);
    k = (k + (k << 3) + (k << 8)) & m;
    k = k ^ (k >> SH_C);
    k = (k + (k << 2) + (k << 4)) & m;
    k = k ^ (k >> SH_D);
    k = (k + (k << SH_E)) & m;
    return k[HASH_W-1:0];
  endfunction

  // Advance the model by one base; fills step_seeds with what it emits
  task automatic predict_seeds(input logic [7:0] b, input logic fin);
    logic [HASH_W-1:0] hv [WINDOW_LEN];
    logic              rc_pick [WINDOW_LEN];
    logic              usable [WINDOW_LEN];
    logic              found;
    logic [HASH_W-1:0] best;
    logic [POS_W-1:0]  floor_pos;
    logic [POS_W-1:0]  loc;
    logic [KM_W-1:0]   f;
    logic [KM_W-1:0]   r;
    logic [7:0]        flip;
    int                age;
    step_seeds.delete();
    if (b == CH_END) begin
      read_pos   = '0;
      clean_run  = '0;
      seed_floor = '0;
      step_seeds.push_back('{hash: '1, pos: '0, rc: 1'b0, eor: 1'b1, last_flag: 1'b0});
    end else begin
      read_pos = read_pos + POS_W'(1);
      if (b == CH_BREAK) begin
        clean_run = '0;
      end else begin
        if (clean_run != '1) clean_run = clean_run + RUN_W'(1);
        flip      = b ^ COMP_FLIP;
        fwd_bases = {fwd_bases[WIN_W-3:0], b[2:1]};
        rc_bases  = {rc_bases[WIN_W-3:0], flip[2:1]};
      end
      // Full window: pick the least canonical hash, emit the new holders
      if (clean_run > RUN_THR) begin
        found     = 1'b0;
        best      = '0;
        floor_pos = seed_floor;
        for (int i = 0; i < WINDOW_LEN; i++) begin
          age = WINDOW_LEN - 1 - i;
          f   = fwd_bases[2*age +: KM_W];
          for (int j = 0; j < KMER_LEN; j++) begin
            r[2*(KMER_LEN-1-j) +: 2] = rc_bases[2*(age+j) +: 2];
          end
          usable[i]  = (f != r);
          rc_pick[i] = (f > r);
          hv[i]      = usable[i] ? scramble30((f > r) ? r : f) : '0;
          if (usable[i] && (!found || hv[i] < best)) begin
            best  = hv[i];
            found = 1'b1;
          end
        end
        for (int i = 0; i < WINDOW_LEN; i++) begin
          loc = read_pos + POS_W'(i) - POS_W'(WINDOW_LEN);
          if (usable[i] && hv[i] == best && loc > floor_pos) begin
            step_seeds.push_back('{hash: hv[i], pos: loc, rc: rc_pick[i], eor: 1'b0,
                                   last_flag: 1'b0});
            seed_floor = loc;
          end
        end
      end
    end
    // Stream end: terminator, then everything back to reset
    if (fin) begin
      step_seeds.push_back('{hash: '1, pos: '0, rc: 1'b1, eor: 1'b1, last_flag: 1'b0});
      fwd_bases  = '0;
      rc_bases   = '0;
      read_pos   = '0;
      clean_run  = '0;
      seed_floor = '0;
    end
    if (step_seeds.size() > 0) step_seeds[step_seeds.size()-1].last_flag = 1'b1;
  endtask

  // Drive one base, wait for its beat, record what it should produce
  task automatic send_base(input logic [7:0] b, input logic fin, input check_e chk);
    int gap;
    in_valid   <= 1'b1;
    base_char  <= b;
    stream_end <= fin;
    do @(posedge clk); while (in_stall);
    items_sent++;
    predict_seeds(b, fin);
    case (chk)
      CHK_PREDICT: foreach (step_seeds[k]) pending_seeds.push_back(step_seeds[k]);
      CHK_NONE: ;
      CHK_MARK:
        pending_seeds.push_back('{hash: '1, pos: '0, rc: 1'b0, eor: 1'b1, last_flag: 1'b1});
      CHK_TERM:
        pending_seeds.push_back('{hash: '1, pos: '0, rc: 1'b1, eor: 1'b1, last_flag: 1'b1});
      CHK_MARK_TERM: begin
        pending_seeds.push_back('{hash: '1, pos: '0, rc: 1'b0, eor: 1'b1, last_flag: 1'b0});
        pending_seeds.push_back('{hash: '1, pos: '0, rc: 1'b1, eor: 1'b1, last_flag: 1'b1});
      end
      default: ;
    endcase
    // Bursts of back-to-back beats separated by random gaps
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(0, 20);
      in_valid  <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver stall pattern: free, random, toggling or mostly held
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(4, 40);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      2:       out_stall <= ~out_stall;
      default: out_stall <= (stall_left[2:0] != 3'd0);
    endcase
  end

  // Output check against the oldest prediction
  always @(posedge clk) begin
    seed_rec_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_seeds.size() == 0) begin
        $error("unexpected seed beat: hash %h pos %0d", seed_hash, seed_pos);
        fails++;
      end else begin
        want = pending_seeds.pop_front();
        if (seed_hash !== want.hash) begin
          $error("seed_hash: expected %h, got %h", want.hash, seed_hash);
          fails++;
        end
        if (seed_pos !== want.pos) begin
          $error("seed_pos: expected %0d, got %0d", want.pos, seed_pos);
          fails++;
        end
        if (strand !== want.rc) begin
          $error("strand: expected %b, got %b", want.rc, strand);
          fails++;
        end
        if (end_of_read !== want.eor) begin
          $error("end_of_read: expected %b, got %b", want.eor, end_of_read);
          fails++;
        end
        if (last !== want.last_flag) begin
          $error("last: expected %b, got %b", want.last_flag, last);
          fails++;
        end
        if (!want.eor) seeds_seen++;
        else if (want.rc) terms_seen++;
        else marks_seen++;
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d seeds pending",
               IDLE_LIMIT, pending_seeds.size());
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus
  initial begin
    logic [7:0] b;
    logic [7:0] motif [4];
    logic       fin;
    bit         drained;
    int         kind;
    int         len;
    int         period;
    int         ending;
    int         pick;
    drained = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int n = 0; n < DIR_ROWS; n++) begin
      send_base(dir_rows[n].b, dir_rows[n].fin, dir_rows[n].chk);
    end

    // Random reads
    while (items_sent < TOTAL_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // raw byte noise, may contain read ends and breaks
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          fin = (k == len - 1) && ($urandom_range(0, 7) == 0);
          send_base(8'($urandom_range(0, 255)), fin, CHK_PREDICT);
        end
      end else begin
        len    = (kind == 1) ? $urandom_range(3, 23) : $urandom_range(24, 64);
        period = (kind == 2) ? $urandom_range(1, 4) : 0;
        ending = $urandom_range(0, 9);
        for (int m = 0; m < 4; m++) motif[m] = NUC_TBL[$urandom_range(0, 7)];
        for (int k = 0; k < len; k++) begin
          if (period != 0) begin
            b = motif[k % period];
          end else begin
            pick = $urandom_range(0, 99);
            if (pick < 90)      b = NUC_TBL[$urandom_range(0, 7)];
            else if (pick < 93) b = CH_BREAK;
            else                b = 8'($urandom_range(0, 255));
          end
          fin = (k == len - 1) && (ending == 7);
          send_base(b, fin, CHK_PREDICT);
        end
        if (ending < 7) send_base(CH_END, (ending == 0), CHK_PREDICT);
      end
      // once, let the pipeline empty completely before going on
      if (!drained && items_sent >= TOTAL_ITEMS / 2) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_seeds.size() != 0);
      end
    end
    in_valid <= 1'b0;

    // Drain and settle
    while (pending_seeds.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_seeds.size() != 0) begin
      $error("%0d expected seeds never arrived", pending_seeds.size());
      fails++;
    end

    $display("run: %0d bases in, %0d seeds, %0d read-end markers, %0d terminators out",
             items_sent, seeds_seen, marks_seen, terms_seen);
    $display("mismatches: %0d", fails);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mse_pkg.sv
hdl/mse_dp.sv
hdl/mse_ctrl.sv
hdl/minimizer_seed_extractor_core.sv
hdl/mse_checker.sv
tb/sv/tb_minimizer_seed_extractor_core.sv
